>>> rtl/wfq_pkg.sv
package wfq_pkg;

	// register indexes
	localparam logic [2:0] REG_SITES = 3'd0;
	localparam logic [2:0] REG_W0    = 3'd1;
	localparam logic [2:0] REG_W1    = 3'd2;
	localparam logic [2:0] REG_W2    = 3'd3;
	localparam logic [2:0] REG_W3    = 3'd4;

	localparam int FIN_W  = 48;
	localparam int DONE_W = 22;
	localparam int NUM_W  = 48;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic fin_start;
		logic fin_next;
		logic div_start;
		logic fin_write;
		logic scan_clear;
		logic scan_step;
		logic emit;
		logic batch_clear;
	} wfq_cmd_t;

	// datapath status back to controller
	typedef struct packed {
		logic div_done;
		logic fin_last;
		logic fin_skip;
		logic scan_last;
		logic none_left;
		logic empty;
	} wfq_stat_t;

endpackage

>>> rtl/wfq_div.sv
module wfq_div import wfq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [16:0]      den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	logic [NUM_W-1:0] quo_q;
	logic [17:0]      rem_q;
	logic [16:0]      den_q;
	logic [5:0]       cnt_q;
	logic             run_q;
	logic             done_q;
	logic [17:0]      trial;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q[16:0], quo_q[NUM_W-1]} - {1'b0, den_q};

	// step counter; done rises at the edge that registers the last shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(NUM_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) run_q <= 1'b0;
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			if (!trial[17]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[16:0], quo_q[NUM_W-1]};
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/wfq_datapath.sv
module wfq_datapath import wfq_pkg::*; #(
	parameter int MAX_REQUESTS = 64,
	parameter int MAX_SITES    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  wfq_cmd_t    cmd,
	output wfq_stat_t   stat,
	input  logic [15:0] req_id,
	input  logic [1:0]  site_index,
	input  logic [15:0] work_time,
	input  logic [2:0]  sites_in_use,
	input  logic [15:0] weight_site0,
	input  logic [15:0] weight_site1,
	input  logic [15:0] weight_site2,
	input  logic [15:0] weight_site3,
	output logic [15:0] out_req_id,
	output logic [1:0]  out_site,
	output logic [21:0] done_time,
	output logic        final_flag,
	output logic        strobe
);

	localparam int AW = $clog2(MAX_REQUESTS);
	localparam int CW = $clog2(MAX_REQUESTS + 1);

	// request and finish stores, one registered read port at idx
	logic [15:0]      id_mem  [MAX_REQUESTS];
	logic [1:0]       site_mem[MAX_REQUESTS];
	logic [15:0]      work_mem[MAX_REQUESTS];
	logic [FIN_W-1:0] fin_mem [MAX_REQUESTS];
	logic [MAX_REQUESTS-1:0] live_q;

	logic [15:0]      rd_id_q;
	logic [1:0]       rd_site_q;
	logic [15:0]      rd_work_q;
	logic [FIN_W-1:0] rd_fin_q;

	logic [CW-1:0]    count_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    best_q;
	logic [15:0]      best_id_q;
	logic [1:0]       best_site_q;
	logic [15:0]      best_work_q;
	logic [FIN_W-1:0] best_fin_q;
	logic             have_q;
	logic             cmp_v_s1;
	logic [AW-1:0]    cmp_idx_s1;
	logic [FIN_W-1:0] sum_q[4];
	logic [DONE_W-1:0] done_q;
	logic             div_done;
	logic [NUM_W-1:0] quo;
	logic [NUM_W-1:0] num;
	logic [16:0]      den;
	logic [15:0]      w0, wi;
	logic [1:0]       s;
	logic [2:0]       active;
	logic             bef;
	logic [FIN_W-1:0] inc;
	logic [FIN_W-1:0] fin_sum;
	logic             site_ok;

	assign site_ok = {1'b0, site_index} < 3'(MAX_SITES);
	assign active  = (sites_in_use > 3'(MAX_SITES)) ? 3'(MAX_SITES) : sites_in_use;
	assign s       = rd_site_q;

	// normalized weight divisor
	always_comb begin
		w0 = (weight_site0 == '0) ? 16'd1 : weight_site0;
		case (s)
			2'd1:    wi = weight_site1;
			2'd2:    wi = weight_site2;
			default: wi = weight_site3;
		endcase
		if (wi == '0) wi = 16'd1;
		num = {32'(rd_work_q) * 32'(w0), 16'd0};
		den = {1'b0, wi} + {1'b0, w0} - 17'd1;
	end

	wfq_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(num), .den(den), .done(div_done), .quo(quo)
	);

	assign inc     = (s == 2'd0) ? {16'd0, rd_work_q, 16'd0} : quo;
	assign fin_sum = sum_q[s] + inc;

	// ordering compare of the entry just read against current best
	always_comb begin
		if (rd_fin_q != best_fin_q) bef = rd_fin_q < best_fin_q;
		else if (rd_id_q != best_id_q) bef = rd_id_q < best_id_q;
		else if (rd_site_q != best_site_q) bef = rd_site_q < best_site_q;
		else bef = rd_work_q < best_work_q;
	end

	// store writes and registered reads
	always_ff @(posedge clk) begin
		if (cmd.load && site_ok && count_q < CW'(MAX_REQUESTS)) begin
			id_mem[count_q[AW-1:0]]   <= req_id;
			site_mem[count_q[AW-1:0]] <= site_index;
			work_mem[count_q[AW-1:0]] <= work_time;
		end
		if (cmd.fin_write) fin_mem[idx_q] <= fin_sum;
		rd_id_q   <= id_mem[idx_q];
		rd_site_q <= site_mem[idx_q];
		rd_work_q <= work_mem[idx_q];
		rd_fin_q  <= fin_mem[idx_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			best_q      <= '0;
			best_id_q   <= '0;
			best_site_q <= '0;
			best_work_q <= '0;
			best_fin_q  <= '0;
			have_q      <= 1'b0;
			cmp_v_s1    <= 1'b0;
			cmp_idx_s1  <= '0;
			live_q      <= '0;
			done_q      <= '0;
			strobe      <= 1'b0;
			done_time   <= '0;
			out_req_id  <= '0;
			out_site    <= '0;
			final_flag  <= 1'b0;
			for (int k = 0; k < 4; k++) sum_q[k] <= '0;
		end else begin
			strobe   <= 1'b0;
			cmp_v_s1 <= cmd.scan_step;
			if (cmd.load && site_ok && count_q < CW'(MAX_REQUESTS))
				count_q <= count_q + CW'(1);
			if (cmd.fin_start) begin
				idx_q <= '0;
				done_q <= '0;
				for (int k = 0; k < 4; k++) sum_q[k] <= '0;
			end
			if (cmd.fin_write) begin
				sum_q[s] <= fin_sum;
				live_q[idx_q] <= 1'b1;
			end
			if (cmd.fin_next) idx_q <= idx_q + AW'(1);
			if (cmd.scan_clear) begin
				idx_q  <= '0;
				have_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				cmp_idx_s1 <= idx_q;
				idx_q <= idx_q + AW'(1);
			end
			// compare in the cycle after the read address was issued
			if (cmp_v_s1 && live_q[cmp_idx_s1] && (!have_q || bef)) begin
				best_q      <= cmp_idx_s1;
				best_id_q   <= rd_id_q;
				best_site_q <= rd_site_q;
				best_work_q <= rd_work_q;
				best_fin_q  <= rd_fin_q;
				have_q      <= 1'b1;
			end
			if (cmd.emit) begin
				live_q[best_q] <= 1'b0;
				done_q     <= done_q + DONE_W'(best_work_q);
				done_time  <= done_q + DONE_W'(best_work_q);
				out_req_id <= best_id_q;
				out_site   <= best_site_q;
				final_flag <= ($countones(live_q) == 1);
				strobe     <= 1'b1;
			end
			if (cmd.batch_clear) begin
				count_q <= '0;
				live_q  <= '0;
			end
		end
	end

	assign stat.div_done  = div_done;
	assign stat.fin_last  = (CW'(idx_q) + CW'(1)) >= count_q;
	assign stat.fin_skip  = {1'b0, s} >= active;
	assign stat.scan_last = (CW'(idx_q) + CW'(1)) >= count_q;
	assign stat.none_left = !have_q;
	assign stat.empty     = count_q == '0;

endmodule

>>> rtl/wfq_ctrl.sv
module wfq_ctrl import wfq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      batch_end,
	input  wfq_stat_t stat,
	output wfq_cmd_t  cmd,
	output logic      busy
);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_FIN  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;
	localparam logic [2:0] ST_FRD  = 3'd5;
	localparam logic [2:0] ST_WAIT = 3'd6;

	logic [2:0] state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (start) begin
				cmd.load = 1'b1;
				if (batch_end) begin
					cmd.fin_start = 1'b1;
					state_d = ST_FRD;
				end
			end
			// store read latency
			ST_FRD: state_d = ST_FIN;
			ST_FIN: begin
				// empty store: nothing to schedule
				if (stat.empty) begin
					cmd.batch_clear = 1'b1;
					state_d = ST_LOAD;
				end else if (stat.fin_skip) begin
					if (stat.fin_last) begin
						cmd.scan_clear = 1'b1;
						state_d = ST_SCAN;
					end else begin
						cmd.fin_next = 1'b1;
						state_d = ST_FRD;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: if (stat.div_done) begin
				cmd.fin_write = 1'b1;
				if (stat.fin_last) begin
					cmd.scan_clear = 1'b1;
					state_d = ST_SCAN;
				end else begin
					cmd.fin_next = 1'b1;
					state_d = ST_FRD;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = ST_WAIT;
			end
			// last compare settles
			ST_WAIT: state_d = ST_EMIT;
			ST_EMIT: begin
				if (stat.none_left) begin
					cmd.batch_clear = 1'b1;
					state_d = ST_LOAD;
				end else begin
					cmd.emit = 1'b1;
					cmd.scan_clear = 1'b1;
					state_d = ST_SCAN;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	assign busy = state_q != ST_LOAD;

endmodule

>>> rtl/weighted_fair_queue_scheduler.sv
// channel   signals                                          direction
// request   start, busy(out), req_id, site_index, work_time, batch_end in
// result    strobe, out_req_id, out_site, done_time, final_flag     out
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready    apb
// loading accepts one request per cycle; busy stays low until batch_end
// scheduling: per scheduled request a store read, divider start,
// 48-step divider and done; per request of an unscheduled site a store
// read and a skip; then per result one scan over the store, a settle
// state and the emit, and one final scan over the store ends the batch
// reset returns the store count, control and config registers to defaults
// results appear with strobe for one cycle; the receiver cannot stall
module weighted_fair_queue_scheduler import wfq_pkg::*; #(
	parameter int MAX_REQUESTS = 64,
	parameter int MAX_SITES    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] req_id,
	input  logic [1:0]  site_index,
	input  logic [15:0] work_time,
	input  logic        batch_end,
	output logic        strobe,
	output logic [15:0] out_req_id,
	output logic [1:0]  out_site,
	output logic [21:0] done_time,
	output logic        final_flag,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0]  sites_q;
	logic [15:0] w0_q, w1_q, w2_q, w3_q;
	wfq_cmd_t    cmd;
	wfq_stat_t   stat;

	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sites_q <= 3'd4;
			w0_q <= 16'd1;
			w1_q <= 16'd1;
			w2_q <= 16'd1;
			w3_q <= 16'd1;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (paddr[4:2])
				REG_SITES: sites_q <= pwdata[2:0];
				REG_W0:    w0_q <= pwdata[15:0];
				REG_W1:    w1_q <= pwdata[15:0];
				REG_W2:    w2_q <= pwdata[15:0];
				REG_W3:    w3_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[4:2])
			REG_SITES: prdata = {29'd0, sites_q};
			REG_W0:    prdata = {16'd0, w0_q};
			REG_W1:    prdata = {16'd0, w1_q};
			REG_W2:    prdata = {16'd0, w2_q};
			REG_W3:    prdata = {16'd0, w3_q};
			default:   prdata = '0;
		endcase
	end

	wfq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .batch_end(batch_end),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	wfq_datapath #(.MAX_REQUESTS(MAX_REQUESTS), .MAX_SITES(MAX_SITES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.req_id(req_id), .site_index(site_index), .work_time(work_time),
		.sites_in_use(sites_q), .weight_site0(w0_q), .weight_site1(w1_q),
		.weight_site2(w2_q), .weight_site3(w3_q),
		.out_req_id(out_req_id), .out_site(out_site), .done_time(done_time),
		.final_flag(final_flag), .strobe(strobe)
	);

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import wfq_pkg::*;

	typedef struct packed {
		logic [15:0] id;
		logic [1:0]  site;
		logic [15:0] work;
		logic        last;
	} request_t;

	typedef struct packed {
		logic [15:0] id;
		logic [1:0]  site;
		logic [21:0] done;
		logic        final_f;
	} grant_t;

	localparam int STORE_DEPTH = 64;
	localparam int SITE_COUNT  = 4;
	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] req_id;
	logic [1:0]  site_index;
	logic [15:0] work_time;
	logic        batch_end;
	logic        strobe;
	logic [15:0] out_req_id;
	logic [1:0]  out_site;
	logic [21:0] done_time;
	logic        final_flag;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	weighted_fair_queue_scheduler dut (.*);

	// scheduler state mirrored in the testbench
	logic [2:0]  cfg_sites;
	logic [15:0] cfg_weight [SITE_COUNT];
	request_t    loaded [STORE_DEPTH];
	int          loaded_n;

	request_t    pending_requests [$];
	grant_t      expected_grants [$];
	request_t    cur_req;
	int          send_gap;
	int          draw_gap;
	int          errors;
	int          grants_seen;
	int          batches_seen;
	int          idle_cycles;

	always #5 clk = ~clk;

	function automatic logic [63:0] eff_weight(int s);
		return (cfg_weight[s] == 16'd0) ? 64'd1 : 64'(cfg_weight[s]);
	endfunction

	// virtual finish increment, unsigned Q32.16 truncated
	function automatic logic [47:0] finish_step(int s, logic [15:0] w);
		logic [63:0] w0;
		logic [63:0] wi;
		if (s == 0)
			return 48'(64'(w) << 16);
		w0 = eff_weight(0);
		wi = eff_weight(s);
		return 48'(((64'(w) * w0) << 16) / (wi + w0 - 64'd1));
	endfunction

	function automatic bit goes_first(logic [47:0] fa, request_t a, logic [47:0] fb, request_t b);
		if (fa != fb) return fa < fb;
		if (a.id != b.id) return a.id < b.id;
		if (a.site != b.site) return a.site < b.site;
		return a.work < b.work;
	endfunction

	// build the emit order for the loaded batch and queue the grants
	task automatic schedule_batch();
		logic [47:0] site_sum [SITE_COUNT];
		logic [47:0] fin [STORE_DEPTH];
		int          order [STORE_DEPTH];
		int          active;
		int          n;
		int          j;
		logic [21:0] acc;
		grant_t      g;
		active = (cfg_sites > SITE_COUNT) ? SITE_COUNT : int'(cfg_sites);
		for (int s = 0; s < SITE_COUNT; s++) site_sum[s] = '0;
		n = 0;
		for (int i = 0; i < loaded_n; i++) begin
			if (int'(loaded[i].site) < active) begin
				site_sum[loaded[i].site] = site_sum[loaded[i].site] +
					finish_step(loaded[i].site, loaded[i].work);
				fin[i] = site_sum[loaded[i].site];
				j = n;
				while (j > 0 && goes_first(fin[i], loaded[i], fin[order[j-1]], loaded[order[j-1]])) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = i;
				n++;
			end
		end
		acc = '0;
		for (int i = 0; i < n; i++) begin
			acc = acc + 22'(loaded[order[i]].work);
			g.id = loaded[order[i]].id;
			g.site = loaded[order[i]].site;
			g.done = acc;
			g.final_f = (i == n - 1);
			expected_grants = {expected_grants, g};
		end
		loaded_n = 0;
		batches_seen++;
	endtask

	task automatic accept_request(request_t r);
		if (loaded_n < STORE_DEPTH) begin
			loaded[loaded_n] = r;
			loaded_n++;
		end
		if (r.last) schedule_batch();
	endtask

	// driver: one request at a time with a random gap before each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req_id <= '0;
			site_index <= '0;
			work_time <= '0;
			batch_end <= 1'b0;
			send_gap <= 0;
		end else if (start && !busy) begin
			accept_request(cur_req);
			draw_gap = $urandom_range(0, 19);
			if (draw_gap == 0 && pending_requests.size() != 0) begin
				cur_req = pending_requests.pop_front();
				{req_id, site_index, work_time, batch_end} <= cur_req;
			end else begin
				start <= 1'b0;
				send_gap <= (draw_gap > 0) ? draw_gap - 1 : 0;
			end
		end else if (!start) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (pending_requests.size() != 0) begin
				cur_req = pending_requests.pop_front();
				{req_id, site_index, work_time, batch_end} <= cur_req;
				start <= 1'b1;
			end
		end
	end

	// monitor: compare each grant against the oldest expected one
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			grants_seen++;
			if (expected_grants.size() == 0) begin
				$error("unexpected grant id=%0d site=%0d", out_req_id, out_site);
				errors++;
			end else begin
				grant_t e;
				e = expected_grants.pop_front();
				if (out_req_id !== e.id) begin
					$error("out_req_id expected %0d got %0d", e.id, out_req_id);
					errors++;
				end
				if (out_site !== e.site) begin
					$error("out_site expected %0d got %0d", e.site, out_site);
					errors++;
				end
				if (done_time !== e.done) begin
					$error("done_time expected %0d got %0d", e.done, done_time);
					errors++;
				end
				if (final_flag !== e.final_f) begin
					$error("final_flag expected %0d got %0d", e.final_f, final_flag);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted transfer
	always @(posedge clk) begin
		if ((start && !busy) || strobe || (psel && penable) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_SITES) cfg_sites = val[2:0];
		else cfg_weight[idx - REG_W0] = val[15:0];
	endtask

	task automatic configure(logic [31:0] sites, logic [31:0] w0, logic [31:0] w1,
			logic [31:0] w2, logic [31:0] w3);
		reg_write(REG_SITES, sites | ($urandom() & 32'hFFFF_FFF8));
		reg_write(REG_W0, w0 | ($urandom() & 32'hFFFF_0000));
		reg_write(REG_W1, w1 | ($urandom() & 32'hFFFF_0000));
		reg_write(REG_W2, w2 | ($urandom() & 32'hFFFF_0000));
		reg_write(REG_W3, w3 | ($urandom() & 32'hFFFF_0000));
	endtask

	task automatic add_req(logic [15:0] id, logic [1:0] s, logic [15:0] w, logic last);
		request_t r;
		r = '{id: id, site: s, work: w, last: last};
		pending_requests = {pending_requests, r};
	endtask

	// random batch; small id and work ranges now and then to force ties
	task automatic add_batch(int n);
		bit narrow;
		narrow = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++)
			add_req(narrow ? 16'($urandom_range(0, 3)) : 16'($urandom()),
				2'($urandom()),
				narrow ? 16'($urandom_range(0, 3)) : 16'($urandom()),
				i == n - 1);
	endtask

	// drain: all requests sent, all grants seen, block idle
	task automatic drain();
		while (pending_requests.size() != 0 || start) @(posedge clk);
		while (expected_grants.size() != 0 || busy) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		grants_seen = 0;
		batches_seen = 0;
		idle_cycles = 0;
		loaded_n = 0;
		cfg_sites = 3'd4;
		for (int s = 0; s < SITE_COUNT; s++) cfg_weight[s] = 16'd1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed requests under reset defaults: extremes and ties
		add_req(16'hFFFF, 2'd3, 16'hFFFF, 1'b0);
		add_req(16'h0000, 2'd0, 16'h0000, 1'b0);
		add_req(16'h0005, 2'd1, 16'h0010, 1'b0);
		add_req(16'h0005, 2'd2, 16'h0010, 1'b0);
		add_req(16'h0005, 2'd2, 16'h0010, 1'b0);
		add_req(16'h0004, 2'd0, 16'h0010, 1'b1);
		add_req(16'h1234, 2'd1, 16'h0001, 1'b1);
		drain();

		// skewed weights with a zero weight, two sites scheduled
		configure(2, 3, 16'hFFFF, 0, 7);
		add_req(16'h0001, 2'd0, 16'h0100, 1'b0);
		add_req(16'h0002, 2'd1, 16'h0100, 1'b0);
		add_req(16'h0003, 2'd3, 16'h0100, 1'b0);
		add_req(16'h0004, 2'd1, 16'hFFFF, 1'b0);
		add_req(16'h0005, 2'd2, 16'h0001, 1'b1);
		// only unscheduled sites: no grants
		add_req(16'h0006, 2'd2, 16'h0009, 1'b0);
		add_req(16'h0007, 2'd3, 16'h0009, 1'b1);
		drain();

		// no site scheduled at all
		configure(0, 1, 1, 1, 1);
		add_req(16'h0008, 2'd0, 16'h0004, 1'b1);
		drain();

		// random phases across settings, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: configure(4, 16'hFFFF, 1, 16'hFFFF, 0);
				1: configure(1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: configure(7, 0, 0, 0, 0);
				default: configure($urandom_range(1, 7), rand_weight(), rand_weight(),
					rand_weight(), rand_weight());
			endcase
			for (int b = 0; b < 3; b++) add_batch($urandom_range(1, 8));
			// one full store with overflow, the last four requests dropped
			if (ph == 3) add_batch(68);
			drain();
		end

		$display("tb_top: %0d batches, %0d grants checked over 11 register settings",
			batches_seen, grants_seen);
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/wfq_pkg.sv
rtl/wfq_div.sv
rtl/wfq_datapath.sv
rtl/wfq_ctrl.sv
rtl/weighted_fair_queue_scheduler.sv
verif/tb_top.sv
